// ===== rtl/core/ped_pkg.sv =====
// Package for the percent-escape decoder: character codes, escape phases,
// the transaction types shared by the core modules, and hex-digit helpers.
// Depends on nothing; every other file of the block but ped_if imports it.
package ped_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_PLUS_AS_SPACE = 3'h0;

   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_0        = 8'h30;
   localparam logic [7:0] CHAR_9        = 8'h39;
   localparam logic [7:0] CHAR_UC_A     = 8'h41;
   localparam logic [7:0] CHAR_UC_F     = 8'h46;
   localparam logic [7:0] CHAR_LC_A     = 8'h61;
   localparam logic [7:0] CHAR_LC_F     = 8'h66;

   // Letter digits have low nibble 1..6 and stand for 10..15.
   localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

   typedef enum logic [1:0] {
      ESC_IDLE  = 2'd0,
      ESC_PCT   = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } result_type;

   // Results of one input item, handed from the decoder to the output buffer.
   typedef struct packed {
      logic [1:0] cnt;
      result_type res0;
      result_type res1;
   } load_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       is_pct;
      logic [7:0] data;
   } plain_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = c[3:0];
      if (c inside {[CHAR_0:CHAR_9]}) begin
         h.value = c[3:0];
      end else if (c inside {[CHAR_UC_A:CHAR_UC_F], [CHAR_LC_A:CHAR_LC_F]}) begin
         h.value = c[3:0] + HEX_LETTER_OFFSET;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   // A character outside an escape: '%' opens one, '+' may become a space.
   function automatic plain_type plain_char(input logic [7:0] c, input logic plus_as_space);
      plain_type p;
      p.is_pct = (c == CHAR_PERCENT);
      p.data   = (plus_as_space && c == CHAR_PLUS) ? CHAR_SPACE : c;
      return p;
   endfunction

endpackage

// ===== rtl/core/ped_if.sv =====
// Stream interfaces of the percent-escape decoder: the request channel that
// carries escaped bytes and the response channel that carries decoded bytes.
// Self-contained; no package needed.
interface ped_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface ped_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/percent_escape_decoder.sv =====
// Top level of the streaming percent-escape (URL) decoder.
// Depends on ped_pkg, ped_if, ped_csr, ped_decode and ped_out_buf.
//
// Usage:
//   req_chan carries one escaped byte per transaction (in_byte, in_last).
//   rsp_chan carries decoded bytes (out_byte, out_last); out_last marks the
//   final decoded byte of a string. A string's last byte always produces at
//   least one result, since an open escape is flushed there.
//   The csr port holds plus_as_space at byte address 0; write it only while
//   the block is idle.
// Timing:
//   A request is held in an input register, decoded combinationally from it
//   and loaded into a two-entry output buffer, whose head slot presents its
//   first result on rsp_chan. One request is taken every cycle while the
//   output buffer has room for its results; a byte that yields two results
//   occupies the response channel for both of them, which is the only source
//   of backpressure besides rsp_chan.ready.
//   When the receiver stalls, results wait in the output buffer and the input
//   register holds one more request before req_chan.ready drops.
// Reset:
//   Synchronous reset empties both stages, leaves the escape state outside an
//   escape and clears plus_as_space.
module percent_escape_decoder
   import ped_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   ped_req_if.sink                   req_chan,
   ped_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic          plus_as_space;
   logic          in_valid_ff;
   logic          in_valid_in;
   logic [7:0]    in_byte_ff;
   logic [7:0]    in_byte_in;
   logic          in_last_ff;
   logic          in_last_in;
   esc_phase_type phase_ff;
   esc_phase_type phase_in;
   logic [3:0]    nibble_ff;
   logic [3:0]    nibble_in;
   esc_phase_type phase_next;
   logic [3:0]    nibble_next;
   load_type      load;
   logic          room;
   logic          advance;
   logic          take;

   ped_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .plus_as_space (plus_as_space)
   );

   ped_decode u_decode (
      .in_byte       (in_byte_ff),
      .in_last       (in_last_ff),
      .plus_as_space (plus_as_space),
      .phase         (phase_ff),
      .nibble        (nibble_ff),
      .load          (load),
      .phase_next    (phase_next),
      .nibble_next   (nibble_next)
   );

   ped_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load_en  (advance),
      .load     (load),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

   // A byte without results never waits for space in the output buffer.
   assign advance        = in_valid_ff && (load.cnt == 2'd0 || room);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      phase_in    = phase_ff;
      nibble_in   = nibble_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         phase_in    = phase_next;
         nibble_in   = nibble_next;
      end
      if (take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.in_byte;
         in_last_in  = req_chan.in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= ESC_IDLE;
         nibble_ff   <= 4'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         nibble_ff   <= nibble_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

endmodule

// ===== rtl/core/ped_csr.sv =====
// APB-style register port of the percent-escape decoder; holds plus_as_space.
// Depends on ped_pkg for the address map.
module ped_csr
   import ped_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic                      plus_as_space
);

   logic plus_ff;
   logic plus_in;
   logic wr_en;
   logic sel_plus;

   assign csr_pready = 1'b1;
   // Byte offsets within a word are ignored; only the word index decodes.
   assign sel_plus   = (csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_ADDR_PLUS_AS_SPACE[CSR_ADDR_WIDTH-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign plus_in    = (wr_en && sel_plus) ? csr_pwdata[0] : plus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_ff <= 1'b0;
      end else begin
         plus_ff <= plus_in;
      end
   end

   assign csr_prdata    = sel_plus ? {{(CSR_DATA_WIDTH-1){1'b0}}, plus_ff} : '0;
   assign plus_as_space = plus_ff;

endmodule

// ===== rtl/core/ped_decode.sv =====
// Combinational decode of one registered input byte against the escape state:
// yields zero, one or two result bytes and the next escape state.
// Depends on ped_pkg for types, character codes and hex helpers.
module ped_decode
   import ped_pkg::*;
(
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   input  logic          plus_as_space,
   input  esc_phase_type phase,
   input  logic [3:0]    nibble,
   output load_type      load,
   output esc_phase_type phase_next,
   output logic [3:0]    nibble_next
);

   always_comb begin
      hex_type       hex;
      plain_type     plain;
      esc_phase_type ph;
      logic [1:0]    n;
      logic [7:0]    e0;
      logic [7:0]    e1;
      logic          flush;
      logic [7:0]    flush_data;

      hex         = hex_decode(in_byte);
      plain       = plain_char(in_byte, plus_as_space);
      ph          = ESC_IDLE;
      n           = 2'd0;
      e0          = plain.data;
      e1          = plain.data;
      nibble_next = nibble;

      case (phase)
         ESC_PCT: begin
            if (hex.valid) begin
               ph          = ESC_DIGIT;
               nibble_next = hex.value;
            end else begin
               // Broken escape: a question mark, then the byte as plain text unless it opens a new escape.
               e0 = CHAR_QUESTION;
               if (plain.is_pct) begin
                  ph = ESC_PCT;
                  n  = 2'd1;
               end else begin
                  n  = 2'd2;
               end
            end
         end
         ESC_DIGIT: begin
            if (hex.valid) begin
               e0 = {nibble, hex.value};
               n  = 2'd1;
            end else begin
               // Single digit: its value, then the byte as plain text unless it opens a new escape.
               e0 = {4'd0, nibble};
               if (plain.is_pct) begin
                  ph = ESC_PCT;
                  n  = 2'd1;
               end else begin
                  n  = 2'd2;
               end
            end
         end
         default: begin
            if (plain.is_pct) begin
               ph = ESC_PCT;
            end else begin
               n  = 2'd1;
            end
         end
      endcase

      // The last byte of a string flushes an open escape as one more result.
      flush      = in_last && (ph == ESC_PCT || ph == ESC_DIGIT);
      flush_data = (ph == ESC_PCT) ? CHAR_QUESTION : {4'd0, nibble_next};
      if (flush) begin
         if (n == 2'd0) begin
            e0 = flush_data;
         end else begin
            e1 = flush_data;
         end
         n = n + 2'd1;
      end

      phase_next     = in_last ? ESC_IDLE : ph;
      load.cnt       = n;
      load.res0.data = e0;
      load.res0.last = in_last && (n == 2'd1);
      load.res1.data = e1;
      load.res1.last = in_last && (n == 2'd2);
   end

endmodule

// ===== rtl/core/ped_out_buf.sv =====
// Two-entry result buffer of the percent-escape decoder: takes all results of
// one input item at once and presents them one per transaction.
// Depends on ped_pkg for the load and result types and on ped_rsp_if.
module ped_out_buf
   import ped_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load_en,
   input  load_type      load,
   output logic          room,
   ped_rsp_if.source     rsp_chan
);

   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   result_type slot0_ff;
   result_type slot0_in;
   result_type slot1_ff;
   result_type slot1_in;
   logic       pop;

   assign rsp_chan.valid    = (cnt_ff != 2'd0);
   assign rsp_chan.out_byte = slot0_ff.data;
   assign rsp_chan.out_last = slot0_ff.last;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   // Results of a new item may enter once every held result leaves this cycle.
   assign room = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (load_en && load.cnt != 2'd0) begin
         cnt_in   = load.cnt;
         slot0_in = load.res0;
         slot1_in = load.res1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== test/percent_escape_decoder_tb.sv =====
// Self-checking testbench for percent_escape_decoder: directed and random escaped text
// is checked against an in-bench decoder model, with bursty input and a stalling receiver.
// Depends on ped_pkg, ped_if and the decoder RTL.
module percent_escape_decoder_tb;
   import ped_pkg::*;

   localparam int HEX_LETTER_BASE = 10;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 220;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } escaped_char_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   ped_req_if req_chan();
   ped_rsp_if rsp_chan();

   percent_escape_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Bench copy of the decoder state and its one register.
   esc_phase_type esc_phase = ESC_IDLE;
   logic [3:0] pending_nibble = 4'h0;
   logic plus_cfg = 1'b0;
   int step_results;

   escaped_char_type escaped_q[$];
   result_type decoded_q[$];
   escaped_char_type next_char;
   result_type want;

   logic req_fired = 1'b0;
   int gap_left = 0;
   int burst_left = 0;
   logic [31:0] stall_pattern = 32'hFFFF_FFFF;
   int pattern_age = 0;

   int mismatches = 0;
   int pushed_count = 0;
   int bytes_taken = 0;
   int strings_ended = 0;
   int results_checked = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Timeout with %0d decoded bytes still expected.", decoded_q.size());
      $display("percent_escape_decoder_tb failed");
      $finish;
   end

   function automatic void note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("ERROR: %s", msg);
      end
   endfunction

   function automatic int hex_of(input logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return int'(c) - int'(CHAR_0);
      if (c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c) - int'(CHAR_LC_A) + HEX_LETTER_BASE;
      if (c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c) - int'(CHAR_UC_A) + HEX_LETTER_BASE;
      return -1;
   endfunction

   // At most two decoded bytes can come out of one escaped byte.
   function automatic void put_result(input logic [7:0] d);
      result_type r;
      if (step_results < 2) begin
         r.data = d;
         r.last = 1'b0;
         decoded_q.push_back(r);
         step_results++;
      end
   endfunction

   function automatic void take_plain(input logic [7:0] c);
      if (c == CHAR_PERCENT) begin
         esc_phase = ESC_PCT;
      end else if (plus_cfg && c == CHAR_PLUS) begin
         put_result(CHAR_SPACE);
      end else begin
         put_result(c);
      end
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic last);
      int digit;
      result_type r;
      digit = hex_of(c);
      step_results = 0;
      case (esc_phase)
         ESC_PCT: begin
            if (digit >= 0) begin
               pending_nibble = digit[3:0];
               esc_phase = ESC_DIGIT;
            end else begin
               esc_phase = ESC_IDLE;
               put_result(CHAR_QUESTION);
               take_plain(c);
            end
         end
         ESC_DIGIT: begin
            esc_phase = ESC_IDLE;
            if (digit >= 0) begin
               put_result({pending_nibble, digit[3:0]});
            end else begin
               put_result({4'h0, pending_nibble});
               take_plain(c);
            end
         end
         default: begin
            esc_phase = ESC_IDLE;
            take_plain(c);
         end
      endcase
      if (last) begin
         // An escape cut short by the end of the string is flushed.
         if (esc_phase == ESC_PCT) begin
            put_result(CHAR_QUESTION);
         end else if (esc_phase == ESC_DIGIT) begin
            put_result({4'h0, pending_nibble});
         end
         esc_phase = ESC_IDLE;
         if (step_results > 0) begin
            r = decoded_q.pop_back();
            r.last = 1'b1;
            decoded_q.push_back(r);
         end
      end
   endfunction

   function automatic void push_char(input logic [7:0] c, input logic last);
      escaped_char_type e;
      e.ch = c;
      e.last = last;
      escaped_q.push_back(e);
      pushed_count++;
   endfunction

   function automatic logic [7:0] hex_char(input int v);
      if (v < HEX_LETTER_BASE) return 8'(int'(CHAR_0) + v);
      return 8'(int'(($urandom_range(0, 1) == 1) ? CHAR_UC_A : CHAR_LC_A) + v - HEX_LETTER_BASE);
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (hex_of(c) >= 0) begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // A string of well-formed and broken pieces, closed by in_last.
   function automatic void queue_string(input int pieces);
      int kind;
      escaped_char_type e;
      for (int k = 0; k < pieces; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            push_char(8'($urandom_range(32, 126)), 1'b0);
         end else if (kind < 45) begin
            push_char(CHAR_PLUS, 1'b0);
         end else if (kind < 75) begin
            push_char(CHAR_PERCENT, 1'b0);
            push_char(hex_char($urandom_range(0, 15)), 1'b0);
            push_char(hex_char($urandom_range(0, 15)), 1'b0);
         end else if (kind < 87) begin
            push_char(CHAR_PERCENT, 1'b0);
            if ($urandom_range(0, 1) == 1) begin
               push_char(hex_char($urandom_range(0, 15)), 1'b0);
            end
            case ($urandom_range(0, 3))
               0: push_char(CHAR_PERCENT, 1'b0);
               1: push_char(CHAR_PLUS, 1'b0);
               default: push_char(non_hex_char(), 1'b0);
            endcase
         end else begin
            push_char(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         push_char(CHAR_PERCENT, 1'b0);
         if ($urandom_range(0, 1) == 1) begin
            push_char(hex_char($urandom_range(0, 15)), 1'b0);
         end
      end
      e = escaped_q.pop_back();
      e.last = 1'b1;
      escaped_q.push_back(e);
   endfunction

   task automatic csr_write_plus(input logic val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_PLUS_AS_SPACE;
      csr_pwdata <= CSR_DATA_WIDTH'(val);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      plus_cfg = val;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_WIDTH'(val)) begin
         note_failure($sformatf("plus_as_space read back %0h, expected %0h", csr_prdata, val));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Let the sender run dry, then wait a bounded time for the last results.
   task automatic wait_drained();
      int waited;
      waited = 0;
      while (escaped_q.size() != 0 || req_chan.valid) @(posedge clock);
      while (decoded_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (decoded_q.size() != 0) begin
         note_failure($sformatf("%0d decoded bytes never arrived", decoded_q.size()));
         decoded_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request side: predict every accepted transaction.
   always @(posedge clock) begin
      req_fired <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         decode_char(req_chan.in_byte, req_chan.in_last);
         bytes_taken++;
         if (req_chan.in_last) strings_ended++;
      end
   end

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (escaped_q.size() > 0) begin
            next_char = escaped_q.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.in_byte <= next_char.ch;
            req_chan.in_last <= next_char.last;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: ready follows a rotating pattern that is periodically replaced by a new random one.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = 32'hFFFF_FFFF;
               1: stall_pattern = $urandom;
               2: stall_pattern = $urandom | $urandom;
               default: stall_pattern = ($urandom & $urandom) | 32'h1;
            endcase
            if (stall_pattern == 32'h0) stall_pattern = 32'h1;
            pattern_age = 64;
         end
         rsp_chan.ready <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
         pattern_age--;
      end
   end

   // Response side: compare each transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (decoded_q.size() == 0) begin
            note_failure($sformatf("decoded byte %02h last=%0b arrived with nothing expected",
                                   rsp_chan.out_byte, rsp_chan.out_last));
         end else begin
            want = decoded_q.pop_front();
            if (rsp_chan.out_byte !== want.data || rsp_chan.out_last !== want.last) begin
               note_failure($sformatf("result %0d: expected %02h last=%0b, got %02h last=%0b",
                                      results_checked, want.data, want.last,
                                      rsp_chan.out_byte, rsp_chan.out_last));
            end
         end
         results_checked++;
      end
   end

   initial begin
      int target;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.in_last = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Escapes of both cases, broken and truncated escapes, and byte extremes.
      csr_write_plus(1'b1);
      push_char(CHAR_PERCENT, 1'b0); push_char("4", 1'b0); push_char("1", 1'b0);
      push_char(CHAR_PERCENT, 1'b0); push_char("f", 1'b0); push_char("F", 1'b0);
      push_char(CHAR_PERCENT, 1'b0); push_char("0", 1'b0); push_char("9", 1'b0);
      push_char(CHAR_PERCENT, 1'b0); push_char("g", 1'b0);
      push_char(CHAR_PERCENT, 1'b0); push_char(CHAR_PERCENT, 1'b0);
      push_char("A", 1'b0); push_char("z", 1'b0);
      push_char(CHAR_PERCENT, 1'b0); push_char(CHAR_PLUS, 1'b0);
      push_char(8'h00, 1'b0); push_char(CHAR_PLUS, 1'b0); push_char(8'hFF, 1'b1);
      push_char(CHAR_PERCENT, 1'b0); push_char("5", 1'b0); push_char(CHAR_PERCENT, 1'b1);
      push_char(CHAR_PERCENT, 1'b1);
      push_char(CHAR_PERCENT, 1'b0); push_char("e", 1'b1);
      wait_drained();

      csr_write_plus(1'b0);
      push_char(CHAR_PLUS, 1'b0); push_char(CHAR_PERCENT, 1'b0); push_char(CHAR_PLUS, 1'b1);
      wait_drained();

      // Random phases; the sender pauses at each boundary until all results are in.
      for (int phase = 0; phase < 5; phase++) begin
         csr_write_plus((phase < 2) ? 1'(phase == 0) : 1'($urandom_range(0, 1)));
         target = pushed_count + PHASE_ITEMS;
         while (pushed_count < target) begin
            if ($urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 4)) begin
                  push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
               end
            end else begin
               queue_string($urandom_range(1, 10));
            end
         end
         wait_drained();
      end

      $display("Decoded %0d escaped bytes in %0d strings into %0d checked bytes,",
               bytes_taken, strings_ended, results_checked);
      $display("with plus-to-space mapping both on and off and %0d mismatches.", mismatches);
      if (mismatches == 0) begin
         $display("percent_escape_decoder_tb passed");
      end else begin
         $display("percent_escape_decoder_tb failed");
      end
      $finish;
   end

endmodule
